// ----- hdl/hsv_to_rgb_converter_core_assert.svh -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core_assert.svh
// Assertion helpers for the HSV to RGB converter. Each macro expects a clock
// named clk and an active-low asynchronous reset named arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// Checks that a property holds at every clock edge outside reset.
`define HSV2RGB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that a condition never becomes true outside reset.
`define HSV2RGB_ASSERT_NEVER(lbl, cond, msg) \
	`HSV2RGB_ASSERT(lbl, !(cond), msg)

`endif

// ----- hdl/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants, sextant codes and stage-to-stage structs of the HSV to
// RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	// Pipeline depth from input register to output register.
	localparam int PIPE_DEPTH = 6;

	// Percent and channel full scale.
	localparam int PCT_FULL = 100;
	localparam int CH_FULL  = 255;
	localparam int HUE_TURN = 360;
	localparam int HUE_SEXT = 60;

	// Reciprocal constants for exact floor division by a constant.
	// floor(x / 360) for x < 2^16: (x * 46604) >> 24.
	localparam int HUE_RECIP       = 46604;
	localparam int HUE_RECIP_SHIFT = 24;
	// floor(x / 100) for x <= 25500: (x * 41944) >> 22.
	localparam int PCT_RECIP       = 41944;
	localparam int PCT_RECIP_SHIFT = 22;
	// floor(v * 255 / 100) folded into one constant.
	localparam int TOP_RECIP       = CH_FULL * PCT_RECIP;
	// floor(x / 60) for x <= 15045: (x * 17477) >> 20.
	localparam int SEXT_RECIP       = 17477;
	localparam int SEXT_RECIP_SHIFT = 20;

	// Hue sextant, named by the color span it covers.
	typedef enum logic [2:0] {
		SEXT_R2Y = 3'd0,
		SEXT_Y2G = 3'd1,
		SEXT_G2C = 3'd2,
		SEXT_C2B = 3'd3,
		SEXT_B2M = 3'd4,
		SEXT_M2R = 3'd5
	} sext_t;

	// Hue split result leaving the third stage.
	typedef struct packed {
		sext_t      sext;
		logic [5:0] rem;
	} hue_split_t;

	// Channel extremes leaving the third stage.
	typedef struct packed {
		logic [7:0] top;
		logic [7:0] bot;
	} level_t;

endpackage

// ----- hdl/hsv2rgb_hue_split.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_hue_split
// Stages one to three: reduces the hue modulo 360 and splits it into a
// sextant and a remainder below 60.
// ----------------------------------------------------------------------------
module hsv2rgb_hue_split (
	input  logic                     clk,
	input  logic                     en,
	input  logic [15:0]              hue,
	output hsv2rgb_pkg::hue_split_t  split_s3
);
	import hsv2rgb_pkg::*;

	logic [31:0] quot_prod;
	logic [7:0]  quot_s1;
	logic [15:0] hue_s1;
	logic [15:0] hue_red;
	logic [8:0]  hue_s2;
	hue_split_t  split_nxt;

	// Quotient by 360 through an exact reciprocal multiply.
	assign quot_prod = 32'(hue) * 32'(HUE_RECIP);

	assign hue_red = hue_s1 - 16'(16'(quot_s1) * 16'(HUE_TURN));

	always_comb begin
		if (hue_s2 < 9'(HUE_SEXT)) begin
			split_nxt.sext = SEXT_R2Y;
			split_nxt.rem  = 6'(hue_s2);
		end else if (hue_s2 < 9'(2 * HUE_SEXT)) begin
			split_nxt.sext = SEXT_Y2G;
			split_nxt.rem  = 6'(hue_s2 - 9'(HUE_SEXT));
		end else if (hue_s2 < 9'(3 * HUE_SEXT)) begin
			split_nxt.sext = SEXT_G2C;
			split_nxt.rem  = 6'(hue_s2 - 9'(2 * HUE_SEXT));
		end else if (hue_s2 < 9'(4 * HUE_SEXT)) begin
			split_nxt.sext = SEXT_C2B;
			split_nxt.rem  = 6'(hue_s2 - 9'(3 * HUE_SEXT));
		end else if (hue_s2 < 9'(5 * HUE_SEXT)) begin
			split_nxt.sext = SEXT_B2M;
			split_nxt.rem  = 6'(hue_s2 - 9'(4 * HUE_SEXT));
		end else begin
			split_nxt.sext = SEXT_M2R;
			split_nxt.rem  = 6'(hue_s2 - 9'(5 * HUE_SEXT));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s1  <= quot_prod[HUE_RECIP_SHIFT +: 8];
			hue_s1   <= hue;
			hue_s2   <= hue_red[8:0];
			split_s3 <= split_nxt;
		end
	end

endmodule

// ----- hdl/hsv2rgb_level.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_level
// Stages one to three: clamps saturation and value, then forms the channel
// maximum and minimum with reciprocal multiplies.
// ----------------------------------------------------------------------------
module hsv2rgb_level (
	input  logic                 clk,
	input  logic                 en,
	input  logic [6:0]           saturation,
	input  logic [6:0]           brightness,
	output hsv2rgb_pkg::level_t  level_s3
);
	import hsv2rgb_pkg::*;

	logic [6:0]  sat_cl;
	logic [6:0]  val_cl;
	logic [30:0] top_prod;
	logic [7:0]  top_s1;
	logic [6:0]  sinv_s1;
	logic [14:0] bot_prod_s2;
	logic [7:0]  top_s2;
	logic [30:0] bot_prod;

	assign sat_cl = (saturation > 7'(PCT_FULL)) ? 7'(PCT_FULL) : saturation;
	assign val_cl = (brightness > 7'(PCT_FULL)) ? 7'(PCT_FULL) : brightness;

	// floor(v * 255 / 100) in one constant multiply.
	assign top_prod = 31'(val_cl) * 31'(TOP_RECIP);

	// floor(top * (100 - s) / 100).
	assign bot_prod = 31'(bot_prod_s2) * 31'(PCT_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			top_s1       <= top_prod[PCT_RECIP_SHIFT +: 8];
			sinv_s1      <= 7'(PCT_FULL) - sat_cl;
			bot_prod_s2  <= 15'(top_s1) * 15'(sinv_s1);
			top_s2       <= top_s1;
			level_s3.top <= top_s2;
			level_s3.bot <= bot_prod[PCT_RECIP_SHIFT +: 8];
		end
	end

endmodule

// ----- hdl/hsv2rgb_mix.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_mix
// Stages four to six: forms the ramp between minimum and maximum and routes
// max, min, rising and falling values to the three channels.
// ----------------------------------------------------------------------------
module hsv2rgb_mix (
	input  logic                     clk,
	input  logic                     en,
	input  hsv2rgb_pkg::hue_split_t  split_s3,
	input  hsv2rgb_pkg::level_t      level_s3,
	output logic [7:0]               red_s6,
	output logic [7:0]               green_s6,
	output logic [7:0]               blue_s6
);
	import hsv2rgb_pkg::*;

	logic [13:0] span_prod_s4;
	sext_t       sext_s4;
	level_t      level_s4;
	logic [28:0] ramp_prod;
	logic [7:0]  ramp_s5;
	sext_t       sext_s5;
	level_t      level_s5;
	logic [7:0]  up_val;
	logic [7:0]  down_val;
	logic [7:0]  red_nxt;
	logic [7:0]  green_nxt;
	logic [7:0]  blue_nxt;

	// floor(span * rem / 60) through an exact reciprocal multiply.
	assign ramp_prod = 29'(span_prod_s4) * 29'(SEXT_RECIP);

	// The ramp never exceeds the span, so neither result wraps.
	assign up_val   = level_s5.bot + ramp_s5;
	assign down_val = level_s5.top - ramp_s5;

	always_comb begin
		case (sext_s5)
			SEXT_R2Y: begin
				red_nxt = level_s5.top; green_nxt = up_val;       blue_nxt = level_s5.bot;
			end
			SEXT_Y2G: begin
				red_nxt = down_val;     green_nxt = level_s5.top; blue_nxt = level_s5.bot;
			end
			SEXT_G2C: begin
				red_nxt = level_s5.bot; green_nxt = level_s5.top; blue_nxt = up_val;
			end
			SEXT_C2B: begin
				red_nxt = level_s5.bot; green_nxt = down_val;     blue_nxt = level_s5.top;
			end
			SEXT_B2M: begin
				red_nxt = up_val;       green_nxt = level_s5.bot; blue_nxt = level_s5.top;
			end
			default: begin
				red_nxt = level_s5.top; green_nxt = level_s5.bot; blue_nxt = down_val;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			span_prod_s4 <= 14'(level_s3.top - level_s3.bot) * 14'(split_s3.rem);
			sext_s4      <= split_s3.sext;
			level_s4     <= level_s3;
			ramp_s5      <= ramp_prod[SEXT_RECIP_SHIFT +: 8];
			sext_s5      <= sext_s4;
			level_s5     <= level_s4;
			red_s6       <= red_nxt;
			green_s6     <= green_nxt;
			blue_s6      <= blue_nxt;
		end
	end

endmodule

// ----- hdl/hsv_to_rgb_converter_core.sv -----
// Throughput: one beat per cycle; the six-stage pipeline advances as a whole
// whenever the output register is empty or its beat is being taken.
// Reset clears only the stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// Converts one HSV color per beat into 8-bit red, green and blue plus the
// 24-bit GRB word in LED strip wire order. Hue is reduced modulo 360;
// saturation and value above 100 percent are clamped to 100.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_core_assert.svh"

module hsv_to_rgb_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] hue,
	input  logic [6:0]  saturation,
	input  logic [6:0]  brightness,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [23:0] grb_word
);
	import hsv2rgb_pkg::*;

	// One valid bit per stage; bit zero is stage one, the top bit is the
	// output register.
	logic [PIPE_DEPTH-1:0] stage_valid_q;
	logic                  advance;
	hue_split_t            split_s3;
	level_t                level_s3;

	// The whole pipeline moves together. It stalls only when the output
	// register holds a beat that the consumer is not taking, so a bubble in
	// the middle never blocks the input while the output is free.
	assign advance  = !stage_valid_q[PIPE_DEPTH-1] || out_ready;
	assign in_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else if (advance) begin
			stage_valid_q <= {stage_valid_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	// Hue path: modulo 360, then sextant and remainder.
	hsv2rgb_hue_split u_hue_split (
		.clk      (clk),
		.en       (advance),
		.hue      (hue),
		.split_s3 (split_s3)
	);

	// Level path: channel maximum and minimum from value and saturation.
	hsv2rgb_level u_level (
		.clk        (clk),
		.en         (advance),
		.saturation (saturation),
		.brightness (brightness),
		.level_s3   (level_s3)
	);

	// Ramp and channel routing; the last stage is the output register.
	hsv2rgb_mix u_mix (
		.clk      (clk),
		.en       (advance),
		.split_s3 (split_s3),
		.level_s3 (level_s3),
		.red_s6   (red),
		.green_s6 (green),
		.blue_s6  (blue)
	);

	assign out_valid = stage_valid_q[PIPE_DEPTH-1];
	assign grb_word  = {green, red, blue};

	// A stalled output beat must stay in the pipeline.
	`HSV2RGB_ASSERT(a_stall_keeps_beat, out_valid && !out_ready |=> out_valid,
		"output beat lost during stall")
	// An accepted input beat must land in stage one.
	`HSV2RGB_ASSERT(a_accept_enters, in_valid && in_ready |=> stage_valid_q[0],
		"accepted beat did not enter stage one")
	// The minimum never exceeds the maximum.
	`HSV2RGB_ASSERT_NEVER(a_level_order, stage_valid_q[2] && (level_s3.bot > level_s3.top),
		"channel minimum above maximum")
	// The hue remainder stays inside one sextant.
	`HSV2RGB_ASSERT_NEVER(a_rem_range, stage_valid_q[2] && (split_s3.rem > 6'(HUE_SEXT - 1)),
		"hue remainder out of range")

endmodule
